// File: design/swst_pkg.sv
// Shared widths, stream layouts and controller/datapath signal bundles
// for the sensor window statistics tracker. No dependencies.
package swst_pkg;

    // Fixed field widths
    localparam int TEMP_W     = 15;
    localparam int PRESS_W    = 17;
    localparam int ALT_W      = 16;
    localparam int SLOT_OUT_W = 7;

    // Input stream layout
    localparam int S_TDATA_W   = 48;
    localparam int IN_TEMP_LSB = 0;
    localparam int IN_PRES_LSB = 15;
    localparam int IN_ALT_LSB  = 32;

    // Output stream layout
    localparam int M_TDATA_W    = 104;
    localparam int M_TUSER_W    = 1;
    localparam int OUT_AVGT_LSB = 0;
    localparam int OUT_AVGP_LSB = 15;
    localparam int OUT_PEAK_LSB = 32;
    localparam int OUT_LOWP_LSB = 47;
    localparam int OUT_SLOT_LSB = 64;
    localparam int OUT_LOGT_LSB = 71;
    localparam int OUT_LOGP_LSB = 86;
    localparam int OUT_PAD_W    = 1;

    localparam logic [PRESS_W-1:0] LOW_PRESS_RESET = '1;

    typedef struct packed {
        logic capture;   // latch the accepted sample, issue ring read
        logic update;    // update sums, ring, peaks and log slot
        logic div_start; // launch one division
        logic div_sel;   // 0: temperature mean, 1: pressure mean
        logic load_out;  // copy results into the output register
    } swst_cmd_t;

    typedef struct packed {
        logic div_done;
    } swst_sts_t;

    localparam logic DIV_SEL_TEMP  = 1'b0;
    localparam logic DIV_SEL_PRESS = 1'b1;

endpackage

// File: design/sensor_window_stats_tracker_unit.sv
// Top level of the sensor window statistics tracker.
// Depends on swst_pkg, swst_ctrl, swst_dp (and through it swst_ram, swst_div).
//
// Usage:
//   Samples enter on the slave stream (s_tvalid/s_tready/s_tdata); one
//   result leaves on the master stream (m_tvalid/m_tready/m_tdata/m_tuser)
//   for every sample. start_altitude_m is loaded through cfg_wr_en and
//   cfg_wr_data while no sample is in flight.
//   Each sample updates a WINDOW-deep boxcar for temperature and pressure
//   (two block RAMs, one read of the oldest entry then one write), a peak
//   temperature, a lowest pressure and an altitude log slot counter.
//   Both means come from one shared restoring divider, one quotient bit a
//   cycle over P_SUM_W = 17 + clog2(WINDOW+1) bits, temperature first.
//   One sample is in work at a time: the next sample is taken only after
//   both divisions have finished and the result has been loaded.
//   The finished result sits in an output register; s_tready rises again
//   as soon as it is loaded, so the next sample can be taken while the
//   receiver stalls. A second result waits in the controller until the
//   output register is free.
//   Reset clears sums, fill count, ring position, peak (to 0), lowest
//   pressure (to all ones), the log slot and start altitude; ring contents
//   are not cleared since a read entry is used only once the ring is full.
module sensor_window_stats_tracker_unit
    import swst_pkg::*;
#(
    parameter int WINDOW    = 1024,
    parameter int LOG_SLOTS = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration: start_altitude_m
    input  logic                 cfg_wr_en,
    input  logic [ALT_W-1:0]     cfg_wr_data,
    // Sample stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata from bit 0: temperature[14:0], pressure[31:15], altitude_m[47:32]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata from bit 0: avg_temperature[14:0], avg_pressure[31:15],
    // peak_temperature[46:32], lowest_pressure[63:47], log_slot[70:64],
    // log_temperature[85:71], log_pressure[102:86], zero pad[103]
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser from bit 0: logged[0]
    output logic [M_TUSER_W-1:0] m_tuser
);
    swst_cmd_t cmd;
    swst_sts_t sts;

    // Sequence each sample: capture, ring read, update, two divisions, output
    swst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Hold all sample-derived state and the output payload
    swst_dp #(
        .WINDOW    (WINDOW),
        .LOG_SLOTS (LOG_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// File: design/swst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/swst_div.sv
// Iterative restoring divider: one quotient bit per cycle, unsigned.
// No dependencies.
module swst_div #(
    parameter int DW = 28,
    parameter int VW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW:0]   shifted;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? VW'(shifted - {1'b0, divisor}) : VW'(shifted);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: design/swst_ctrl.sv
// Sequencing state machine: handshakes, ring access order, divisions, output.
// Depends on swst_pkg.
module swst_ctrl
    import swst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output swst_cmd_t cmd,
    input  swst_sts_t sts
);
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_READ    = 3'd1;
    localparam logic [2:0] ST_UPDATE  = 3'd2;
    localparam logic [2:0] ST_START_T = 3'd3;
    localparam logic [2:0] ST_WAIT_T  = 3'd4;
    localparam logic [2:0] ST_START_P = 3'd5;
    localparam logic [2:0] ST_WAIT_P  = 3'd6;
    localparam logic [2:0] ST_OUT     = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = DIV_SEL_TEMP;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_START_T;
            end
            ST_START_T:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_T;
            end
            ST_WAIT_T:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_START_P;
                end
            end
            ST_START_P:
            begin
                cmd.div_sel   = DIV_SEL_PRESS;
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_P;
            end
            ST_WAIT_P:
            begin
                cmd.div_sel = DIV_SEL_PRESS;
                if (sts.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/swst_dp.sv
// Datapath: sample registers, sample rings, running sums, peak hold,
// log slot tracking, shared divider and output payload register.
// Depends on swst_pkg, swst_ram, swst_div.
module swst_dp
    import swst_pkg::*;
#(
    parameter int WINDOW    = 1024,
    parameter int LOG_SLOTS = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [ALT_W-1:0]       cfg_wr_data,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic [M_TUSER_W-1:0]   m_tuser,
    input  swst_cmd_t              cmd,
    output swst_sts_t              sts
);
    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int T_SUM_W = TEMP_W + CNT_W;
    localparam int P_SUM_W = PRESS_W + CNT_W;
    localparam int SLOT_W  = $clog2(LOG_SLOTS + 1);
    localparam int GAIN_W  = ALT_W + 1;

    // Configuration
    logic [ALT_W-1:0] start_alt_reg;

    // Sample
    logic [TEMP_W-1:0]  t_reg;
    logic [PRESS_W-1:0] p_reg;
    logic [ALT_W-1:0]   alt_reg;

    // Window state
    logic [T_SUM_W-1:0] t_sum_reg, t_sum_next;
    logic [P_SUM_W-1:0] p_sum_reg, p_sum_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               full;
    logic [TEMP_W-1:0]  ring_t_rd, old_t;
    logic [PRESS_W-1:0] ring_p_rd, old_p;

    // Peaks and log
    logic [TEMP_W-1:0]  peak_reg;
    logic [PRESS_W-1:0] low_reg;
    logic [SLOT_W-1:0]  next_slot_reg;
    logic [GAIN_W-1:0]  gain;
    logic               do_log;
    logic               logged_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [TEMP_W-1:0]  log_t_reg;
    logic [PRESS_W-1:0] log_p_reg;

    // Division
    logic               div_done;
    logic [P_SUM_W-1:0] div_dividend, div_quo;
    logic [T_SUM_W-1:0] t_mag;
    logic               t_neg_reg;
    logic [TEMP_W-1:0]  avg_t_reg;
    logic [PRESS_W-1:0] avg_p_reg;

    // Output payload
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_alt_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            start_alt_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            t_reg   <= s_tdata[IN_TEMP_LSB +: TEMP_W];
            p_reg   <= s_tdata[IN_PRES_LSB +: PRESS_W];
            alt_reg <= s_tdata[IN_ALT_LSB +: ALT_W];
        end
    end

    swst_ram #(.WIDTH(TEMP_W), .DEPTH(WINDOW)) u_ram_t (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (pos_reg),
        .wdata (t_reg),
        .re    (cmd.capture),
        .raddr (pos_reg),
        .rdata (ring_t_rd)
    );

    swst_ram #(.WIDTH(PRESS_W), .DEPTH(WINDOW)) u_ram_p (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (pos_reg),
        .wdata (p_reg),
        .re    (cmd.capture),
        .raddr (pos_reg),
        .rdata (ring_p_rd)
    );

    // Drop the oldest sample only once the ring is full
    assign full  = (fill_reg == CNT_W'(WINDOW));
    assign old_t = full ? ring_t_rd : '0;
    assign old_p = full ? ring_p_rd : '0;

    assign t_sum_next = t_sum_reg
                      + {{(T_SUM_W-TEMP_W){t_reg[TEMP_W-1]}}, t_reg}
                      - {{(T_SUM_W-TEMP_W){old_t[TEMP_W-1]}}, old_t};
    assign p_sum_next = p_sum_reg + P_SUM_W'(p_reg) - P_SUM_W'(old_p);
    assign pos_next   = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;

    assign gain   = {alt_reg[ALT_W-1], alt_reg}
                  - {start_alt_reg[ALT_W-1], start_alt_reg};
    assign do_log = (next_slot_reg < SLOT_W'(LOG_SLOTS))
                  && ($signed(gain) > $signed(GAIN_W'(next_slot_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_sum_reg     <= '0;
            p_sum_reg     <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            peak_reg      <= '0;
            low_reg       <= LOW_PRESS_RESET;
            next_slot_reg <= '0;
        end
        else if (cmd.update)
        begin
            t_sum_reg <= t_sum_next;
            p_sum_reg <= p_sum_next;
            pos_reg   <= pos_next;
            if (!full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if ($signed(t_reg) > $signed(peak_reg))
            begin
                peak_reg <= t_reg;
            end
            if (p_reg < low_reg)
            begin
                low_reg <= p_reg;
            end
            if (do_log)
            begin
                next_slot_reg <= next_slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            logged_reg <= do_log;
            slot_reg   <= do_log ? next_slot_reg : '0;
            log_t_reg  <= do_log ? t_reg : '0;
            log_p_reg  <= do_log ? p_reg : '0;
        end
    end

    // Divide magnitudes, restore the temperature sign afterwards
    assign t_mag        = t_sum_reg[T_SUM_W-1] ? (~t_sum_reg + 1'b1) : t_sum_reg;
    assign div_dividend = (cmd.div_sel == DIV_SEL_PRESS) ? p_sum_reg : P_SUM_W'(t_mag);

    swst_div #(.DW(P_SUM_W), .VW(CNT_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign sts.div_done = div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start && (cmd.div_sel == DIV_SEL_TEMP))
        begin
            t_neg_reg <= t_sum_reg[T_SUM_W-1];
        end
        if (div_done && (cmd.div_sel == DIV_SEL_TEMP))
        begin
            avg_t_reg <= t_neg_reg ? (~div_quo[TEMP_W-1:0] + 1'b1) : div_quo[TEMP_W-1:0];
        end
        if (div_done && (cmd.div_sel == DIV_SEL_PRESS))
        begin
            avg_p_reg <= div_quo[PRESS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}},
                             log_p_reg,
                             log_t_reg,
                             SLOT_OUT_W'(slot_reg),
                             low_reg,
                             peak_reg,
                             avg_p_reg,
                             avg_t_reg};
            out_user_reg <= logged_reg;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

// File: design/swst_checker.sv
// Port-level checks for the sensor window statistics tracker, bound to the top.
// Depends on swst_pkg and sensor_window_stats_tracker_unit.
module swst_checker
    import swst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser
);
    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One sample at a time: ready drops right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample taken while one is in work");

    // Log fields read zero when no slot is filled
    a_log_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[102:64] == '0)
        else $error("log fields nonzero without a log");

    // Peak starts at zero and only rises, so it is never negative
    a_peak_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[OUT_PEAK_LSB + TEMP_W - 1])
        else $error("negative peak temperature");

endmodule

bind sensor_window_stats_tracker_unit swst_checker u_swst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
